// ===== src/bal_pkg.sv =====
// Shared codes, field widths and payload types for the bounded array list.
package bal_pkg;

  // Transaction field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 10;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Commands
  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_READ   = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== src/bal_in_if.sv =====
// Request channel: command, position and data word with valid/ready.
interface bal_in_if import bal_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  pos_t  position;
  word_t data_in;

  modport source (output valid, command, position, data_in, input ready);
  modport sink   (input valid, command, position, data_in, output ready);
endinterface

// ===== src/bal_out_if.sv =====
// Response channel: data word, status, count and empty flag with valid/ready.
interface bal_out_if import bal_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   data_out;
  status_t status;
  count_t  count;
  logic    empty_res;

  modport source (output valid, data_out, status, count, empty_res, input ready);
  modport sink   (input valid, data_out, status, count, empty_res, output ready);
endinterface

// ===== src/bal_mem.sv =====
// Entry storage: one write port, one read port, registered read data.
module bal_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bal_ctrl.sv =====
// Command sequencer: range checks, append, read, and shift-down on removal.
module bal_ctrl import bal_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 10,
  parameter int CW         = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  bal_in_if.sink                req,
  bal_out_if.source             rsp,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         count, count_next;
  cmd_t                  cmd, cmd_next;
  pos_t                  pos, pos_next;
  logic [DATA_WIDTH-1:0] word, word_next;
  logic [AW-1:0]         wr_ptr, wr_ptr_next;
  word_t                 res_data, res_data_next;
  status_t               res_status, res_status_next;

  logic                  out_valid, out_valid_next;
  word_t                 out_data, out_data_next;
  status_t               out_status, out_status_next;
  count_t                out_count, out_count_next;
  logic                  out_empty, out_empty_next;

  logic [CMPW-1:0]       pos_ext, cnt_ext, pos_inc;
  logic [CW:0]           ptr1, ptr2, cnt1;

  assign pos_ext = CMPW'(pos);
  assign cnt_ext = CMPW'(count);
  assign pos_inc = pos_ext + CMPW'(1);
  assign ptr1    = (CW+1)'(wr_ptr) + (CW+1)'(1);
  assign ptr2    = (CW+1)'(wr_ptr) + (CW+1)'(2);
  assign cnt1    = (CW+1)'(count);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.data_out  = out_data;
  assign rsp.status    = out_status;
  assign rsp.count     = out_count;
  assign rsp.empty_res = out_empty;

  // Next-state logic
  always_comb begin
    state_next      = state;
    count_next      = count;
    cmd_next        = cmd;
    pos_next        = pos;
    word_next       = word;
    wr_ptr_next     = wr_ptr;
    res_data_next   = res_data;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    out_status_next = out_status;
    out_count_next  = out_count;
    out_empty_next  = out_empty;
    mem_we          = 1'b0;
    mem_waddr       = wr_ptr;
    mem_wdata       = mem_rdata;
    mem_raddr       = '0;

    // Response register drains independently of the sequencer
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_next   = req.command;
          pos_next   = req.position;
          word_next  = DATA_WIDTH'(req.data_in);
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_next   = '0;
        res_status_next = ST_OK;
        state_next      = S_DONE;
        case (cmd)
          CMD_APPEND: begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = word;
              count_next = count + CW'(1);
            end
          end
          CMD_READ, CMD_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              res_status_next = ST_RANGE;
            end else begin
              mem_raddr  = pos_ext[AW-1:0];
              state_next = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        res_data_next = WORD_W'(mem_rdata);
        if (cmd == CMD_REMOVE) begin
          // Prime the read of the entry that moves into the hole
          wr_ptr_next = pos_ext[AW-1:0];
          mem_raddr   = pos_inc[AW-1:0];
          state_next  = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // rdata holds entry wr_ptr+1; move it down, fetch the next one
        if (ptr1 < cnt1) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr;
          mem_wdata   = mem_rdata;
          mem_raddr   = ptr2[AW-1:0];
          wr_ptr_next = ptr1[AW-1:0];
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_data_next   = res_data;
          out_status_next = res_status;
          out_count_next  = COUNT_W'(count);
          out_empty_next  = (count == '0);
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    pos        <= pos_next;
    word       <= word_next;
    wr_ptr     <= wr_ptr_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
    out_empty  <= out_empty_next;
  end

endmodule

// ===== src/bounded_array_list.sv =====
// A request is captured in idle, then executed; append, unused command and
// out-of-range index go straight to done, a read first waits for the registered
// memory data, and a remove also shifts each later entry down, one entry per cycle.
// Done then loads the response register, waiting while a held response is stalled.
// One request is in work at a time; the next is taken once the response is loaded.
// Reset (rst, synchronous) empties the list at once; entry storage is not cleared.
module bounded_array_list import bal_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  bal_in_if.sink    req,
  bal_out_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  bal_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  bal_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ===== src/bal_checker.sv =====
// Port-level checks for the bounded array list, bound to the top level.
module bal_checker import bal_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input word_t   rsp_data_out,
  input status_t rsp_status,
  input count_t  rsp_count,
  input logic    rsp_empty_res
);

  logic       req_fire, rsp_fire;
  logic [1:0] pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending <= pending + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pending <= pending - 2'd1;
    end
  end

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) &&
      $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_empty_res))
    else $error("response changed while stalled");

  // No response without a request behind it
  a_no_extra_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("response transaction with no pending request");

  // At most one request in work plus one waiting response
  a_depth: assert property (@(posedge clk) disable iff (rst)
    req_fire |-> pending <= 2'd1)
    else $error("request taken with two outstanding");

  // A refused append only happens at capacity and returns no data
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |->
      rsp_count == COUNT_W'(CAPACITY) && rsp_data_out == '0)
    else $error("list-full status with wrong count or data");

endmodule

bind bounded_array_list bal_checker #(.CAPACITY(CAPACITY)) u_bal_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_data_out (rsp.data_out),
  .rsp_status   (rsp.status),
  .rsp_count    (rsp.count),
  .rsp_empty_res(rsp.empty_res)
);
